@@ rtl/bsr_pkg.sv @@
`timescale 1ns / 1ps
package bsr_pkg;

    // Width of the window register and of the pending byte count
    localparam int CNT_W = 7;
    // Width of the stream index on the channels
    localparam int PORT_IDX_W = 32;

    // Control of the shared add/subtract unit: y = a + (sub ? ~b : b) + (sub | cin)
    typedef struct packed {
        logic sub;
        logic cin;
    } t_alu_op;

endpackage

@@ rtl/bsr_ifs.sv @@
`timescale 1ns / 1ps
interface bsr_in_if;
    import bsr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PORT_IDX_W-1:0] stream_index;
    logic [7:0]            data_byte;
    logic                  byte_valid;
    logic                  end_of_stream;

    modport source (output valid, stream_index, data_byte, byte_valid, end_of_stream,
                    input ready);
    modport sink   (input valid, stream_index, data_byte, byte_valid, end_of_stream,
                    output ready);
endinterface

interface bsr_out_if;
    import bsr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [7:0]            out_byte;
    logic                  byte_present;
    logic                  last_of_run;
    logic                  stream_ended;
    logic [CNT_W-1:0]      pending_bytes;
    logic [PORT_IDX_W-1:0] next_expected;

    modport source (output valid, out_byte, byte_present, last_of_run, stream_ended,
                    pending_bytes, next_expected, input ready);
    modport sink   (input valid, out_byte, byte_present, last_of_run, stream_ended,
                    pending_bytes, next_expected, output ready);
endinterface

interface bsr_cfg_if;
    import bsr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] window_limit;

    modport source (output valid, window_limit, input ready);
    modport sink   (input valid, window_limit, output ready);
endinterface

@@ rtl/bsr_ram.sv @@
`timescale 1ns / 1ps
module bsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bsr_addsub.sv @@
`timescale 1ns / 1ps
module bsr_addsub
    import bsr_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  t_alu_op          i_op,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_y
);

    logic [WIDTH-1:0] b_eff;
    logic             carry;

    assign b_eff = i_op.sub ? ~i_b : i_b;
    assign carry = i_op.sub | i_op.cin;
    assign o_y   = i_a + b_eff + WIDTH'(carry);

endmodule

@@ rtl/byte_stream_reassembler.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Moves
// i_in      sink       stream_index, data_byte, byte_valid, end_of_stream
// o_out     source     out_byte, byte_present, last_of_run, stream_ended,
//                      pending_bytes, next_expected
// i_cfg     sink       window_limit (always ready)
//
// An input transaction passes through accept and window check, then end offset
// and end distance when it carries an end mark, then check and load per delivered
// byte, or check alone for an empty result. The steps are set by the one shared
// adder/subtractor, used once per step, and by the registered read of the byte ring.
// Synchronous active-low reset clears valid marks and status; no clearing pass.
// A result waiting in the output register holds the sequencer before its next
// result; i_in is ready only while the sequencer is idle.
module byte_stream_reassembler
    import bsr_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64,
    parameter int INDEX_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bsr_in_if.sink    i_in,
    bsr_out_if.source o_out,
    bsr_cfg_if.sink   i_cfg
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WIN   = 6'b000010,
        S_EOFF  = 6'b000100,
        S_EDIST = 6'b001000,
        S_CHECK = 6'b010000,
        S_LOAD  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Item and stream state
    logic [INDEX_BITS-1:0]   r_idx, n_idx;
    logic [7:0]              r_data;
    logic                    r_bv, r_eos;
    logic [INDEX_BITS-1:0]   r_next, n_next;
    logic [SLOT_W-1:0]       r_head, n_head;
    logic [CNT_W-1:0]        r_pend, n_pend;
    logic                    r_end_known, n_end_known;
    logic [INDEX_BITS-1:0]   r_end_pos, n_end_pos;
    logic [CNT_W-1:0]        r_window;
    logic [WINDOW_DEPTH-1:0] r_marks, n_marks;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_byte, n_out_byte;
    logic                  r_out_present, n_out_present;
    logic                  r_out_last, n_out_last;
    logic                  r_out_ended, n_out_ended;
    logic [CNT_W-1:0]      r_out_pend, n_out_pend;
    logic [PORT_IDX_W-1:0] r_out_next, n_out_next;

    // Shared unit
    t_alu_op               alu_op;
    logic [INDEX_BITS-1:0] alu_a, alu_b, alu_y;

    logic [CNT_W-1:0]  w_eff;
    logic              dist_small;
    logic              in_win, end_in_win;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] head_inc;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic [63:0]       in_idx_ext;
    logic [63:0]       next_ext;
    logic              in_fire, out_fire;

    assign in_fire  = i_in.valid & i_in.ready;
    assign out_fire = r_out_valid & o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign in_idx_ext = 64'(i_in.stream_index);
    assign next_ext   = 64'(r_next);

    assign w_eff = (r_window > DEPTH_CNT) ? DEPTH_CNT : r_window;

    bsr_addsub #(.WIDTH(INDEX_BITS)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    always_comb begin
        alu_op = '{sub: 1'b1, cin: 1'b0};
        alu_a  = r_idx;
        alu_b  = r_next;
        case (r_state)
            S_EOFF: begin
                alu_op = '{sub: 1'b0, cin: r_bv};
                alu_a  = r_idx;
                alu_b  = '0;
            end
            S_CHECK: begin
                alu_op = '{sub: 1'b0, cin: 1'b1};
                alu_a  = r_next;
                alu_b  = '0;
            end
            default: begin
                alu_op = '{sub: 1'b1, cin: 1'b0};
                alu_a  = r_idx;
                alu_b  = r_next;
            end
        endcase
    end

    // Distance checks on the unit output
    assign dist_small = (alu_y[INDEX_BITS-1:CNT_W] == '0);
    assign in_win     = dist_small && (alu_y[CNT_W-1:0] < w_eff);
    assign end_in_win = dist_small && (alu_y[CNT_W-1:0] <= w_eff);

    // d < WINDOW_DEPTH here, so one conditional subtract wraps the slot
    assign slot_sum = (SLOT_W + 1)'(r_head) + (SLOT_W + 1)'(alu_y[SLOT_W-1:0]);
    assign slot     = (slot_sum >= DEPTH_EXT) ? SLOT_W'(slot_sum - DEPTH_EXT)
                                              : slot_sum[SLOT_W-1:0];
    assign head_inc = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;

    assign ram_we = (r_state == S_WIN) && r_bv && in_win && !r_marks[slot];

    bsr_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (r_data),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_next        = r_next;
        n_head        = r_head;
        n_pend        = r_pend;
        n_end_known   = r_end_known;
        n_end_pos     = r_end_pos;
        n_marks       = r_marks;
        n_out_valid   = out_fire ? 1'b0 : r_out_valid;
        n_out_byte    = r_out_byte;
        n_out_present = r_out_present;
        n_out_last    = r_out_last;
        n_out_ended   = r_out_ended;
        n_out_pend    = r_out_pend;
        n_out_next    = r_out_next;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_idx   = in_idx_ext[INDEX_BITS-1:0];
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                if (ram_we) begin
                    n_marks[slot] = 1'b1;
                    n_pend        = r_pend + 1'b1;
                end
                n_state = r_eos ? S_EOFF : S_CHECK;
            end
            S_EOFF: begin
                n_idx   = alu_y;
                n_state = S_EDIST;
            end
            S_EDIST: begin
                if (end_in_win) begin
                    n_end_known = 1'b1;
                    n_end_pos   = r_idx;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_out_valid || out_fire) begin
                    if (r_marks[r_head]) begin
                        // ring read of this slot lands in S_LOAD
                        n_marks[r_head] = 1'b0;
                        n_head          = head_inc;
                        n_next          = alu_y;
                        if (r_pend != '0) begin
                            n_pend = r_pend - 1'b1;
                        end
                        n_state = S_LOAD;
                    end else begin
                        // nothing to deliver: one status-only result
                        n_out_valid   = 1'b1;
                        n_out_byte    = '0;
                        n_out_present = 1'b0;
                        n_out_last    = 1'b1;
                        n_out_ended   = r_end_known && (r_next == r_end_pos);
                        n_out_pend    = r_pend;
                        n_out_next    = next_ext[PORT_IDX_W-1:0];
                        n_state       = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                n_out_valid   = 1'b1;
                n_out_byte    = ram_rdata;
                n_out_present = 1'b1;
                n_out_last    = !r_marks[r_head];
                n_out_ended   = r_end_known && (r_next == r_end_pos);
                n_out_pend    = r_pend;
                n_out_next    = next_ext[PORT_IDX_W-1:0];
                n_state       = r_marks[r_head] ? S_CHECK : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next      <= '0;
            r_head      <= '0;
            r_pend      <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= '0;
            r_marks     <= '0;
            r_window    <= CNT_W'(64);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_head      <= n_head;
            r_pend      <= n_pend;
            r_end_known <= n_end_known;
            r_end_pos   <= n_end_pos;
            r_marks     <= n_marks;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_window <= i_cfg.window_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_out_byte    <= n_out_byte;
        r_out_present <= n_out_present;
        r_out_last    <= n_out_last;
        r_out_ended   <= n_out_ended;
        r_out_pend    <= n_out_pend;
        r_out_next    <= n_out_next;
        if (in_fire) begin
            r_data <= i_in.data_byte;
            r_bv   <= i_in.byte_valid;
            r_eos  <= i_in.end_of_stream;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.byte_present  = r_out_present;
    assign o_out.last_of_run   = r_out_last;
    assign o_out.stream_ended  = r_out_ended;
    assign o_out.pending_bytes = r_out_pend;
    assign o_out.next_expected = r_out_next;

endmodule
